// ===== hw/rtl/sukt_pkg.sv =====
`timescale 1ns / 1ps

package sukt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int POS_CMP_W = (IDX_W > 6) ? IDX_W : 6;

   localparam int GROUP_SIZE = 8;
   localparam int GROUP_CNT_W = $clog2(GROUP_SIZE + 1);
   localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [2:0] FUNC_INSERT = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_LOOKUP = 3'd2;
   localparam logic [2:0] FUNC_SET_TYPE = 3'd3;
   localparam logic [2:0] FUNC_COUNT = 3'd4;
   localparam logic [2:0] FUNC_READ = 3'd5;

   localparam logic [2:0] STATUS_DONE = 3'd0;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_FULL = 3'd3;
   localparam logic [2:0] STATUS_POS_EMPTY = 3'd4;

   typedef struct packed {
      logic by_pos;
      logic insert_en;
      logic remove_en;
      logic set_type_en;
   } cell_ctl_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] key;
      logic [7:0]         entry_type;
      logic [CNT_W-1:0]   type_count;
   } gather_type;

endpackage

// ===== hw/rtl/sukt_cell.sv =====
`timescale 1ns / 1ps

module sukt_cell (
   input  logic                         clock,
   input  logic [sukt_pkg::IDX_W-1:0]   index,
   input  logic [sukt_pkg::CNT_W-1:0]   count,
   input  sukt_pkg::cell_ctl_type       ctl,
   input  logic signed [31:0]           cmd_key,
   input  logic [7:0]                   cmd_type,
   input  logic [5:0]                   cmd_pos,
   input  logic                         prev_lt,
   input  logic signed [31:0]           prev_key,
   input  logic [7:0]                   prev_type,
   input  logic signed [31:0]           next_key,
   input  logic [7:0]                   next_type,
   output logic signed [31:0]           key_q,
   output logic [7:0]                   type_q,
   output logic                         lt,
   output logic                         hit,
   output logic                         tmatch
);
   import sukt_pkg::*;

   logic signed [31:0] key_ff, key_in;
   logic [7:0]         type_ff, type_in;
   logic               occupied;
   logic               key_lt;

   assign occupied = CNT_W'(index) < count;
   assign key_lt   = key_ff < cmd_key;
   assign lt       = occupied && key_lt;
   assign tmatch   = occupied && (type_ff == cmd_type);
   assign hit      = occupied && (ctl.by_pos ? (POS_CMP_W'(index) == POS_CMP_W'(cmd_pos))
                                             : (key_ff == cmd_key));

   always_comb begin
      key_in  = key_ff;
      type_in = type_ff;
      if (ctl.insert_en && !lt) begin
         if (prev_lt) begin
            key_in  = cmd_key;
            type_in = cmd_type;
         end else begin
            key_in  = prev_key;
            type_in = prev_type;
         end
      end else if (ctl.remove_en && occupied && !key_lt) begin
         key_in  = next_key;
         type_in = next_type;
      end else if (ctl.set_type_en && hit) begin
         type_in = cmd_type;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      type_ff <= type_in;
   end

   assign key_q  = key_ff;
   assign type_q = type_ff;

endmodule

// ===== hw/rtl/sukt_gather.sv =====
`timescale 1ns / 1ps

module sukt_gather (
   input  logic                                     clock,
   input  logic [sukt_pkg::TABLE_DEPTH-1:0]         hit,
   input  logic [sukt_pkg::TABLE_DEPTH-1:0]         tmatch,
   input  logic [sukt_pkg::TABLE_DEPTH-1:0][31:0]   keys,
   input  logic [sukt_pkg::TABLE_DEPTH-1:0][7:0]    types,
   output sukt_pkg::gather_type                     result
);
   import sukt_pkg::*;

   logic [NUM_GROUPS-1:0]                   ghit_ff, ghit_in;
   logic [NUM_GROUPS-1:0][31:0]             gkey_ff, gkey_in;
   logic [NUM_GROUPS-1:0][7:0]              gtype_ff, gtype_in;
   logic [NUM_GROUPS-1:0][GROUP_CNT_W-1:0]  gcnt_ff, gcnt_in;
   gather_type                              result_ff, result_in;

   // first level: groups of eight cells
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         ghit_in[g]  = 1'b0;
         gkey_in[g]  = '0;
         gtype_in[g] = '0;
         gcnt_in[g]  = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < TABLE_DEPTH) begin
               ghit_in[g]  = ghit_in[g] | hit[g * GROUP_SIZE + j];
               gkey_in[g]  = gkey_in[g] | (keys[g * GROUP_SIZE + j]
                                           & {32{hit[g * GROUP_SIZE + j]}});
               gtype_in[g] = gtype_in[g] | (types[g * GROUP_SIZE + j]
                                            & {8{hit[g * GROUP_SIZE + j]}});
               gcnt_in[g]  = gcnt_in[g] + GROUP_CNT_W'(tmatch[g * GROUP_SIZE + j]);
            end
         end
      end
   end

   // second level: across groups
   always_comb begin
      result_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         result_in.hit        = result_in.hit | ghit_ff[g];
         result_in.key        = result_in.key | gkey_ff[g];
         result_in.entry_type = result_in.entry_type | gtype_ff[g];
         result_in.type_count = result_in.type_count + CNT_W'(gcnt_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      ghit_ff   <= ghit_in;
      gkey_ff   <= gkey_in;
      gtype_ff  <= gtype_in;
      gcnt_ff   <= gcnt_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== hw/rtl/sorted_unique_key_table_unit.sv =====
`timescale 1ns / 1ps
// a command passes through the compare, gather and update states, and the result strobe is
//    registered at the end of the update step; busy stays high through compare, gather and
//    update in the cell chain and its two-level gather tree, so no new command is taken meanwhile
// reset: synchronous, clears the entry count and control; cell contents are not cleared
// the result is shown for one cycle only; the receiver cannot stall

module sorted_unique_key_table_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_key,
   input  logic [7:0]         req_entry_type,
   input  logic [5:0]         req_position,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_found_key,
   output logic [7:0]         rsp_found_type,
   output logic [6:0]         rsp_type_count,
   output logic [6:0]         rsp_occupancy
);
   import sukt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;
   localparam logic [1:0] S_EXEC = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [2:0]         func_ff;
   logic signed [31:0] key_ff;
   logic [7:0]         type_ff;
   logic [5:0]         pos_ff;

   logic               strobe_ff, strobe_in;
   logic [2:0]         status_ff, status_in;
   logic signed [31:0] fkey_ff, fkey_in;
   logic [7:0]         ftype_ff, ftype_in;
   logic [6:0]         tcount_ff, tcount_in;
   logic [6:0]         occ_ff, occ_in;

   logic                                accept;
   logic                                exec;
   logic                                full;
   cell_ctl_type                        ctl;
   gather_type                          gath;
   logic [TABLE_DEPTH-1:0]              cell_hit, cell_tmatch, cell_lt;
   logic [TABLE_DEPTH-1:0][31:0]        cell_key;
   logic [TABLE_DEPTH-1:0][7:0]         cell_type;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign exec   = (state_ff == S_EXEC);
   assign full   = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      ctl.by_pos      = (func_ff == FUNC_READ);
      ctl.insert_en   = exec && (func_ff == FUNC_INSERT) && !gath.hit && !full;
      ctl.remove_en   = exec && (func_ff == FUNC_REMOVE) && gath.hit;
      ctl.set_type_en = exec && (func_ff == FUNC_SET_TYPE) && gath.hit;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic               prev_lt;
      logic signed [31:0] prev_key, next_key;
      logic [7:0]         prev_type, next_type;

      if (i == 0) begin : g_first
         assign prev_lt   = 1'b1;
         assign prev_key  = cell_key[i];
         assign prev_type = cell_type[i];
      end else begin : g_mid
         assign prev_lt   = cell_lt[i-1];
         assign prev_key  = cell_key[i-1];
         assign prev_type = cell_type[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_key  = cell_key[i];
         assign next_type = cell_type[i];
      end else begin : g_notlast
         assign next_key  = cell_key[i+1];
         assign next_type = cell_type[i+1];
      end

      sukt_cell u_cell (
         .clock     (clock),
         .index     (IDX_W'(i)),
         .count     (count_ff),
         .ctl       (ctl),
         .cmd_key   (key_ff),
         .cmd_type  (type_ff),
         .cmd_pos   (pos_ff),
         .prev_lt   (prev_lt),
         .prev_key  (prev_key),
         .prev_type (prev_type),
         .next_key  (next_key),
         .next_type (next_type),
         .key_q     (cell_key[i]),
         .type_q    (cell_type[i]),
         .lt        (cell_lt[i]),
         .hit       (cell_hit[i]),
         .tmatch    (cell_tmatch[i])
      );
   end

   sukt_gather u_gather (
      .clock  (clock),
      .hit    (cell_hit),
      .tmatch (cell_tmatch),
      .keys   (cell_key),
      .types  (cell_type),
      .result (gath)
   );

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_CMP : S_IDLE;
         S_CMP:   state_in = S_SUM;
         S_SUM:   state_in = S_EXEC;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      strobe_in = exec;
      status_in = STATUS_DONE;
      fkey_in   = key_ff;
      ftype_in  = '0;
      tcount_in = '0;
      occ_in    = 7'(count_in);
      unique case (func_ff)
         FUNC_INSERT: begin
            if (gath.hit) begin
               status_in = STATUS_DUPLICATE;
            end else if (full) begin
               status_in = STATUS_FULL;
            end
         end
         FUNC_REMOVE, FUNC_SET_TYPE: begin
            if (!gath.hit) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         FUNC_LOOKUP: begin
            if (gath.hit) begin
               ftype_in = gath.entry_type;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         FUNC_COUNT: begin
            tcount_in = 7'(gath.type_count);
         end
         FUNC_READ: begin
            if (gath.hit) begin
               fkey_in  = gath.key;
               ftype_in = gath.entry_type;
            end else begin
               status_in = STATUS_POS_EMPTY;
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         type_ff <= req_entry_type;
         pos_ff  <= req_position;
      end
      if (exec) begin
         status_ff <= status_in;
         fkey_ff   <= fkey_in;
         ftype_ff  <= ftype_in;
         tcount_ff <= tcount_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_found_key  = fkey_ff;
   assign rsp_found_type = ftype_ff;
   assign rsp_type_count = tcount_ff;
   assign rsp_occupancy  = occ_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EXEC))
      else $error("result strobe without update step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_strobe))
      else $error("command transfer not followed by busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> $onehot0(cell_hit))
      else $error("more than one cell matched");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> (count_ff == $past(count_ff)))
      else $error("entry count changed outside update step");

endmodule
